@@ src/pldd_pkg.sv @@
// ----------------------------------------------------------------------------
// pldd_pkg: shared types and constants of the posting-list delta decoder
// Byte classes, the token passed from the front to the back, decode phases
// and register map constants.
// ----------------------------------------------------------------------------
package pldd_pkg;

   // Input item kinds.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   // Width of an assembled number (at most 31 value bits).
   localparam int VALUE_W = 31;
   localparam int TOTAL_W = 32;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_POST_COUNT = 1'b0;

   typedef enum logic [2:0] {
      CLS_START   = 3'd0,
      CLS_WHOLE   = 3'd1,
      CLS_LEAD    = 3'd2,
      CLS_CONT    = 3'd3,
      CLS_INVALID = 3'd4
   } pldd_class_type;

   typedef enum logic [1:0] {
      PH_LOC_OR_FLAG = 2'd0,
      PH_DOC_DELTA   = 2'd1,
      PH_NEW_LOC     = 2'd2
   } pldd_phase_type;

   typedef struct packed {
      pldd_class_type cls;
      logic [6:0]     bits;
      logic [2:0]     cont_count;
   } pldd_token_type;

endpackage

@@ src/posting_list_delta_decoder_core.sv @@
// ----------------------------------------------------------------------------
// posting_list_delta_decoder_core: posting-list delta decoder, top level
// Decodes a stream of variable-length delta-coded numbers into postings.
// ----------------------------------------------------------------------------
// Usage: each req item is either a start marker (req_kind = 0), which clears
// the running document, location and count of posts, or one byte of the
// encoded posting stream (req_kind = 1). Every completed post, and every
// broken byte sequence, produces one rsp item carrying doc, location,
// last_post and malformed. Lead bytes, bytes inside a number, new-document
// flags and document deltas produce no rsp item. Once post_count posts have
// been delivered, later data bytes are dropped until the next start marker.
// Throughput is one item per cycle while the token queue has room. An item
// accepted at a clock edge is written into the token queue at that edge; the
// back end later takes it from the queue and registers its result for rsp.
// req_stall rises only when the token queue is full. When rsp_stall is held,
// the result register keeps its item, the back end pauses and the queue fills
// before req_stall is raised. Synchronous reset clears the queue, all decode
// state, the result valid flag and post_count; there is no clearing pass.
// post_count is written through the csr port at byte address 0.
// ----------------------------------------------------------------------------
module posting_list_delta_decoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [7:0]                           req_data_byte,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [31:0]                          rsp_doc,
   output logic [31:0]                          rsp_location,
   output logic                                 rsp_last_post,
   output logic                                 rsp_malformed,
   // Configuration port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pldd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pldd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pldd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   pldd_pkg::pldd_token_type front_token;
   pldd_pkg::pldd_token_type head_token;
   logic        queue_full;
   logic        queue_not_empty;
   logic        push;
   logic        pop;
   logic        reg_hit;
   logic [31:0] post_count_ff, post_count_in;

   // Register decode: the word index sits above the byte offset.
   assign reg_hit    = (csr_paddr[2] == pldd_pkg::REG_POST_COUNT);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? post_count_ff : '0;

   always_comb begin
      post_count_in = post_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         post_count_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_count_ff <= '0;
      end else begin
         post_count_ff <= post_count_in;
      end
   end

   // The front end accepts whenever the queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   pldd_front u_front (
      .kind      (req_kind),
      .data_byte (req_data_byte),
      .token     (front_token)
   );

   pldd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (front_token),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .head_token (head_token)
   );

   // The back end pops whenever its result register is free or draining.
   pldd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (queue_not_empty),
      .in_token      (head_token),
      .in_take       (pop),
      .post_count    (post_count_ff),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_doc       (rsp_doc),
      .out_location  (rsp_location),
      .out_last_post (rsp_last_post),
      .out_malformed (rsp_malformed)
   );

endmodule

@@ src/pldd_front.sv @@
// ----------------------------------------------------------------------------
// pldd_front: byte classifier
// Sorts each incoming item into start, whole number, lead byte, continuation
// byte or invalid byte, and extracts its value bits.
// ----------------------------------------------------------------------------
module pldd_front (
   input  logic                    kind,
   input  logic [7:0]              data_byte,
   output pldd_pkg::pldd_token_type token
);

   always_comb begin
      token.cls        = pldd_pkg::CLS_INVALID;
      token.bits       = '0;
      token.cont_count = '0;
      if (kind == pldd_pkg::KIND_START) begin
         token.cls = pldd_pkg::CLS_START;
      end else if (!data_byte[7]) begin
         token.cls  = pldd_pkg::CLS_WHOLE;
         token.bits = data_byte[6:0];
      end else if (!data_byte[6]) begin
         token.cls  = pldd_pkg::CLS_CONT;
         token.bits = {1'b0, data_byte[5:0]};
      end else if (!data_byte[5]) begin
         token.cls        = pldd_pkg::CLS_LEAD;
         token.bits       = {2'b0, data_byte[4:0]};
         token.cont_count = 3'd1;
      end else if (!data_byte[4]) begin
         token.cls        = pldd_pkg::CLS_LEAD;
         token.bits       = {3'b0, data_byte[3:0]};
         token.cont_count = 3'd2;
      end else if (!data_byte[3]) begin
         token.cls        = pldd_pkg::CLS_LEAD;
         token.bits       = {4'b0, data_byte[2:0]};
         token.cont_count = 3'd3;
      end else if (!data_byte[2]) begin
         token.cls        = pldd_pkg::CLS_LEAD;
         token.bits       = {5'b0, data_byte[1:0]};
         token.cont_count = 3'd4;
      end else if (!data_byte[1]) begin
         token.cls        = pldd_pkg::CLS_LEAD;
         token.bits       = {6'b0, data_byte[0]};
         token.cont_count = 3'd5;
      end
   end

endmodule

@@ src/pldd_fifo.sv @@
// ----------------------------------------------------------------------------
// pldd_fifo: token queue between front and back
// A small register queue; full is decoded from the registered count, so the
// input stall never depends combinationally on the output side.
// ----------------------------------------------------------------------------
module pldd_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pldd_pkg::pldd_token_type push_token,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output pldd_pkg::pldd_token_type head_token
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pldd_pkg::pldd_token_type entry_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");
`endif

endmodule

@@ src/pldd_back.sv @@
// ----------------------------------------------------------------------------
// pldd_back: number assembly and posting update
// Assembles variable-length numbers from tokens, applies them to the running
// document and location, counts posts and holds the result register.
// ----------------------------------------------------------------------------
module pldd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  pldd_pkg::pldd_token_type in_token,
   output logic                     in_take,
   input  logic [31:0]              post_count,
   output logic                     out_valid,
   input  logic                     out_stall,
   output logic [31:0]              out_doc,
   output logic [31:0]              out_location,
   output logic                     out_last_post,
   output logic                     out_malformed
);

   localparam int VW = pldd_pkg::VALUE_W;
   localparam int TW = pldd_pkg::TOTAL_W;

   pldd_pkg::pldd_phase_type phase_ff, phase_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic [2:0]    rem_ff, rem_in;
   logic [TW-1:0] doc_ff, doc_in;
   logic [TW-1:0] loc_ff, loc_in;
   logic [TW-1:0] posts_ff, posts_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] rsp_doc_ff, rsp_loc_ff;
   logic          rsp_last_ff, rsp_bad_ff;

   logic          emit, emit_last, emit_bad;
   logic          have_value;
   logic [VW-1:0] value, acc_shift;
   logic          finished;

   assign in_take   = in_valid && (!rsp_valid_ff || !out_stall);
   assign finished  = (posts_ff >= post_count);
   assign acc_shift = {acc_ff[VW-7:0], in_token.bits[5:0]};

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      doc_in     = doc_ff;
      loc_in     = loc_ff;
      posts_in   = posts_ff;
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_bad   = 1'b0;
      have_value = 1'b0;
      value      = '0;
      if (in_take) begin
         if (in_token.cls == pldd_pkg::CLS_START) begin
            phase_in = pldd_pkg::PH_LOC_OR_FLAG;
            acc_in   = '0;
            rem_in   = '0;
            doc_in   = '0;
            loc_in   = '0;
            posts_in = '0;
         end else if (!finished) begin
            if (rem_ff == 3'd0) begin
               case (in_token.cls)
                  pldd_pkg::CLS_WHOLE: begin
                     have_value = 1'b1;
                     value      = VW'(in_token.bits);
                  end
                  pldd_pkg::CLS_LEAD: begin
                     acc_in = VW'(in_token.bits);
                     rem_in = in_token.cont_count;
                  end
                  default: begin
                     emit     = 1'b1;
                     emit_bad = 1'b1;
                  end
               endcase
            end else if (in_token.cls == pldd_pkg::CLS_CONT) begin
               rem_in = rem_ff - 3'd1;
               if (rem_ff == 3'd1) begin
                  have_value = 1'b1;
                  value      = acc_shift;
                  acc_in     = '0;
               end else begin
                  acc_in = acc_shift;
               end
            end else begin
               // Broken sequence: the partial number is thrown away.
               acc_in   = '0;
               rem_in   = '0;
               emit     = 1'b1;
               emit_bad = 1'b1;
            end

            if (have_value) begin
               unique case (phase_ff)
                  pldd_pkg::PH_DOC_DELTA: begin
                     doc_in   = doc_ff + TW'(value);
                     phase_in = pldd_pkg::PH_NEW_LOC;
                  end
                  pldd_pkg::PH_NEW_LOC: begin
                     loc_in   = TW'(value);
                     phase_in = pldd_pkg::PH_LOC_OR_FLAG;
                     posts_in = posts_ff + 1'b1;
                     emit     = 1'b1;
                  end
                  default: begin
                     if (value == '0) begin
                        phase_in = pldd_pkg::PH_DOC_DELTA;
                     end else begin
                        phase_in = pldd_pkg::PH_LOC_OR_FLAG;
                        loc_in   = loc_ff + TW'(value);
                        posts_in = posts_ff + 1'b1;
                        emit     = 1'b1;
                     end
                  end
               endcase
               emit_last = emit && (posts_in >= post_count);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_take) begin
         rsp_valid_in = emit;
      end else if (!out_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pldd_pkg::PH_LOC_OR_FLAG;
         acc_ff       <= '0;
         rem_ff       <= '0;
         doc_ff       <= '0;
         loc_ff       <= '0;
         posts_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         rem_ff       <= rem_in;
         doc_ff       <= doc_in;
         loc_ff       <= loc_in;
         posts_ff     <= posts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && emit) begin
         rsp_doc_ff  <= doc_in;
         rsp_loc_ff  <= loc_in;
         rsp_last_ff <= emit_last;
         rsp_bad_ff  <= emit_bad;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_doc       = rsp_doc_ff;
   assign out_location  = rsp_loc_ff;
   assign out_last_post = rsp_last_ff;
   assign out_malformed = rsp_bad_ff;

`ifndef ASSERT_OFF
   a_bad_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> !rsp_last_ff)
      else $error("malformed result marked as last post");
   a_acc_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rem_ff == 3'd0) |-> (acc_ff == '0))
      else $error("accumulator not clear between numbers");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'd5)
      else $error("continuation count out of range");
   a_posts_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (posts_ff == $past(posts_ff) ||
                         posts_ff == $past(posts_ff) + 1'b1 ||
                         posts_ff == '0))
      else $error("post counter jumped");
`endif

endmodule

@@ dv/tb_posting_list_delta_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_posting_list_delta_decoder_core: self-checking posting-list decoder test
// Feeds start markers and encoded posting bytes into the decoder, predicts
// every post and every malformed-sequence result in a built-in decoder model,
// and checks the result stream field by field under random sender idling and
// receiver stalls. post_count is rewritten between lists through the csr port.
// ----------------------------------------------------------------------------
module tb_posting_list_delta_decoder_core;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS   = 200;
   localparam logic [pldd_pkg::CSR_ADDR_W-1:0] POST_COUNT_ADDR =
      pldd_pkg::CSR_ADDR_W'(4 * int'(pldd_pkg::REG_POST_COUNT));

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } stream_item_type;

   typedef struct packed {
      logic [31:0] doc;
      logic [31:0] location;
      logic        last_post;
      logic        malformed;
   } posting_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid     = 1'b0;
   logic                            req_stall;
   logic                            req_kind      = pldd_pkg::KIND_START;
   logic [7:0]                      req_data_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_stall     = 1'b0;
   logic [31:0]                     rsp_doc;
   logic [31:0]                     rsp_location;
   logic                            rsp_last_post;
   logic                            rsp_malformed;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [pldd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [pldd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [pldd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Items waiting for the driver, and the posts the decoder owes us.
   stream_item_type pending_items[$];
   posting_type     expected_posts[$];

   int queued_count   = 0;
   int accepted_count = 0;
   int counted_items  = 0;  // accepted items that were not simply dropped
   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   bit req_accepted   = 1'b0;

   // Decoder model state. post_count_cfg mirrors the csr register.
   logic [31:0]              post_count_cfg = '0;
   pldd_pkg::pldd_phase_type phase_q        = pldd_pkg::PH_LOC_OR_FLAG;
   logic [31:0]              number_bits    = '0;
   logic [2:0]               cont_left      = '0;
   logic [31:0]              doc_sum        = '0;
   logic [31:0]              loc_sum        = '0;
   logic [31:0]              posts_emitted  = '0;

   posting_list_delta_decoder_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_doc       (rsp_doc),
      .rsp_location  (rsp_location),
      .rsp_last_post (rsp_last_post),
      .rsp_malformed (rsp_malformed),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------

   function automatic void note_failure(string msg);
      error_count++;
      $display("%0t: %s", $time, msg);
   endfunction

   function automatic void push_posting(logic last, logic bad);
      posting_type entry;
      entry.doc       = doc_sum;
      entry.location  = loc_sum;
      entry.last_post = last;
      entry.malformed = bad;
      expected_posts  = {expected_posts, entry};
   endfunction

   // Applies one accepted item to the model and queues the result it causes.
   function automatic void decode_stream_item(stream_item_type it);
      logic [31:0] value;
      logic        complete;
      value    = '0;
      complete = 1'b0;
      if (it.kind == pldd_pkg::KIND_START) begin
         // A start marker wipes the list state but keeps post_count.
         phase_q       = pldd_pkg::PH_LOC_OR_FLAG;
         number_bits   = '0;
         cont_left     = '0;
         doc_sum       = '0;
         loc_sum       = '0;
         posts_emitted = '0;
         counted_items++;
         return;
      end
      // A finished list swallows data bytes until the next start marker.
      if (posts_emitted >= post_count_cfg) begin
         return;
      end
      counted_items++;
      if (cont_left == 3'd0) begin
         casez (it.data_byte)
            8'b0???????: begin
               value    = {24'h0, it.data_byte};
               complete = 1'b1;
            end
            8'b110?????: begin
               number_bits = {27'h0, it.data_byte[4:0]};
               cont_left   = 3'd1;
            end
            8'b1110????: begin
               number_bits = {28'h0, it.data_byte[3:0]};
               cont_left   = 3'd2;
            end
            8'b11110???: begin
               number_bits = {29'h0, it.data_byte[2:0]};
               cont_left   = 3'd3;
            end
            8'b111110??: begin
               number_bits = {30'h0, it.data_byte[1:0]};
               cont_left   = 3'd4;
            end
            8'b1111110?: begin
               number_bits = {31'h0, it.data_byte[0]};
               cont_left   = 3'd5;
            end
            // A stray continuation byte, 0xFE or 0xFF cannot open a number.
            default: push_posting(1'b0, 1'b1);
         endcase
      end else if (it.data_byte[7:6] != 2'b10) begin
         // The partial number is thrown away along with the bad byte.
         number_bits = '0;
         cont_left   = '0;
         push_posting(1'b0, 1'b1);
      end else begin
         number_bits = {number_bits[25:0], it.data_byte[5:0]};
         cont_left   = cont_left - 3'd1;
         if (cont_left == 3'd0) begin
            value       = number_bits;
            number_bits = '0;
            complete    = 1'b1;
         end
      end
      if (!complete) begin
         return;
      end
      if (phase_q == pldd_pkg::PH_DOC_DELTA) begin
         doc_sum += value;
         phase_q  = pldd_pkg::PH_NEW_LOC;
         return;
      end
      if (phase_q == pldd_pkg::PH_NEW_LOC) begin
         loc_sum = value;
      end else if (value == 32'h0) begin
         // Zero in the location slot flags a new document.
         phase_q = pldd_pkg::PH_DOC_DELTA;
         return;
      end else begin
         loc_sum += value;
      end
      phase_q = pldd_pkg::PH_LOC_OR_FLAG;
      posts_emitted++;
      push_posting(posts_emitted >= post_count_cfg, 1'b0);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------

   function automatic void queue_item(logic kind, logic [7:0] data_byte);
      stream_item_type entry;
      entry.kind      = kind;
      entry.data_byte = data_byte;
      pending_items   = {pending_items, entry};
      queued_count++;
   endfunction

   // Encodes v in exactly len bytes; longer than needed gives an overlong form.
   function automatic void queue_number(logic [30:0] v, int len);
      logic [7:0] lead;
      if (len <= 1) begin
         queue_item(pldd_pkg::KIND_DATA, {1'b0, v[6:0]});
         return;
      end
      lead = 8'hFF << (8 - len);
      lead = lead | 8'((v >> (6 * (len - 1))) & ((31'h1 << (7 - len)) - 31'h1));
      queue_item(pldd_pkg::KIND_DATA, lead);
      for (int i = len - 2; i >= 0; i--) begin
         queue_item(pldd_pkg::KIND_DATA, {2'b10, 6'(v >> (6 * i))});
      end
   endfunction

   // Shortest legal form most of the time, an overlong one now and then.
   function automatic void queue_value(logic [30:0] v);
      int len;
      len = 6;
      if ((v >> 7) == 0) begin
         len = 1;
      end else begin
         for (int n = 5; n >= 2; n--) begin
            if ((v >> (5 * n + 1)) == 0) begin
               len = n;
            end
         end
      end
      if ($urandom_range(99) < 20) begin
         len = $urandom_range(len, 6);
      end
      queue_number(v, len);
   endfunction

   // Random magnitude so that short and long forms both show up often.
   function automatic logic [30:0] random_value();
      int bits;
      bits = $urandom_range(0, 31);
      return 31'($urandom) & 31'((64'h1 << bits) - 64'h1);
   endfunction

   // One well-formed post: a location delta, or flag + doc delta + location.
   function automatic void queue_posting();
      logic [30:0] delta;
      if ($urandom_range(99) < 70) begin
         delta = random_value();
         if (delta == 31'h0) begin
            delta = 31'h1;
         end
         queue_value(delta);
      end else begin
         queue_value(31'h0);
         queue_value(random_value());
         queue_value(random_value());
      end
   endfunction

   // Garbage and broken sequences.
   function automatic void queue_noise();
      int         len;
      logic [7:0] b;
      case ($urandom_range(3))
         0: queue_item(pldd_pkg::KIND_DATA, 8'($urandom));
         1: queue_item(pldd_pkg::KIND_DATA, {2'b10, 6'($urandom)});
         2: queue_item(pldd_pkg::KIND_DATA, {7'h7F, 1'($urandom)});
         default: begin
            // A lead byte whose number is cut short by a non-continuation byte.
            len = $urandom_range(2, 6);
            b   = (8'hFF << (8 - len)) | 8'($urandom & ((1 << (7 - len)) - 1));
            queue_item(pldd_pkg::KIND_DATA, b);
            repeat ($urandom_range(0, len - 2)) begin
               queue_item(pldd_pkg::KIND_DATA, {2'b10, 6'($urandom)});
            end
            b = 8'($urandom);
            if (b[7:6] == 2'b10) begin
               b[6] = 1'b1;
            end
            queue_item(pldd_pkg::KIND_DATA, b);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Sequencing helpers
   // ------------------------------------------------------------------------

   // Holds until every queued item went in and every post came back. Some
   // items cause no result, so a settling wait at the end lets the pipeline empty.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || accepted_count != queued_count ||
                 expected_posts.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write of post_count followed by a read-back of the same register.
   task automatic write_post_count(logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= POST_COUNT_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      post_count_cfg = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (csr_prdata !== value) begin
         note_failure($sformatf("post_count read-back: expected %h, actual %h",
                                value, csr_prdata));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One list: pick a post count, usually restart, then posts mixed with
   // noise. A few extra posts past the count check that the tail is dropped.
   // Skipping the start marker continues the old list under a new count.
   task automatic run_list();
      int          sel;
      int          posts;
      logic [31:0] count;
      wait_drained();
      sel = $urandom_range(99);
      if (sel < 5) begin
         count = 32'h0;
      end else if (sel < 15) begin
         count = 32'hFFFF_FFFF;
      end else if (sel < 22) begin
         count = $urandom;
      end else begin
         count = $urandom_range(1, 12);
      end
      write_post_count(count);
      if ($urandom_range(99) < 85) begin
         queue_item(pldd_pkg::KIND_START, 8'($urandom));
      end
      if (count == 32'h0) begin
         posts = 3;
      end else if (count > 32'd12) begin
         posts = $urandom_range(8, 30);
      end else begin
         posts = int'(count) + $urandom_range(0, 2);
      end
      repeat (posts) begin
         if ($urandom_range(99) < 12) begin
            queue_noise();
         end else begin
            queue_posting();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents the next pending item once the current one is taken.
   // Idling is a coin toss that never looks at req_stall.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      stream_item_type next_item;
      if (!reset && (!req_valid || req_accepted)) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending_items.pop_front();
            req_valid     <= 1'b1;
            req_kind      <= next_item.kind;
            req_data_byte <= next_item.data_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // ------------------------------------------------------------------------
   // Monitor: runs the model on every accepted item and checks every result
   // against the oldest post still owed.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      posting_type want;
      req_accepted = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_stream_item('{req_kind, req_data_byte});
            accepted_count++;
            req_accepted = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_posts.size() == 0) begin
               note_failure($sformatf({"unexpected result: expected none, actual ",
                  "doc %h loc %h last %b malformed %b"},
                  rsp_doc, rsp_location, rsp_last_post, rsp_malformed));
            end else begin
               want = expected_posts.pop_front();
               if (rsp_doc !== want.doc || rsp_location !== want.location ||
                   rsp_last_post !== want.last_post ||
                   rsp_malformed !== want.malformed) begin
                  note_failure($sformatf({"result mismatch: expected doc %h loc %h ",
                     "last %b malformed %b, actual doc %h loc %h last %b malformed %b"},
                     want.doc, want.location, want.last_post, want.malformed,
                     rsp_doc, rsp_location, rsp_last_post, rsp_malformed));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   // A hung handshake or a lost result ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("posting_list_delta_decoder_core regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int send_idle_by_phase[4];
      int stall_by_phase[4];
      int target;
      send_idle_by_phase = '{0, 69, 0, 25};
      stall_by_phase     = '{0, 0, 69, 25};
      reset         = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. post_count is still 0 after reset, so this byte is
      // dropped without a result.
      queue_item(pldd_pkg::KIND_DATA, 8'h05);
      wait_drained();
      write_post_count(32'hFFFF_FFFF);
      queue_item(pldd_pkg::KIND_START, 8'hFF);
      queue_number(31'd1, 1);             // smallest location delta
      queue_number(31'd127, 1);           // largest one-byte number
      queue_number(31'd0, 1);             // new-document flag
      queue_number(31'h7FFF_FFFF, 6);     // largest doc delta, six bytes
      queue_number(31'd0, 1);             // new location of zero
      queue_number(31'h0000_FFFF, 3);     // largest three-byte number
      queue_number(31'd1, 2);             // overlong form of one
      queue_item(pldd_pkg::KIND_DATA, 8'h80);  // stray continuation byte
      queue_item(pldd_pkg::KIND_DATA, 8'hFE);
      queue_item(pldd_pkg::KIND_DATA, 8'hFF);
      queue_item(pldd_pkg::KIND_DATA, 8'hC3);  // lead byte, then a broken continuation
      queue_item(pldd_pkg::KIND_DATA, 8'h41);
      queue_number(31'd2, 1);             // decoding resumes cleanly
      wait_drained();
      // Short list: the second post is the last, the third byte is dropped.
      write_post_count(32'd2);
      queue_item(pldd_pkg::KIND_START, 8'h00);
      queue_number(31'd5, 1);
      queue_number(31'd6, 1);
      queue_number(31'd7, 1);

      // Random part, one idling pattern per phase. Every list drains before
      // the next count is written, so the sender regularly waits for all
      // outstanding results.
      target = counted_items;
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         send_idle_pct = send_idle_by_phase[p];
         stall_pct     = stall_by_phase[p];
         target += PHASE_ITEMS;
         while (counted_items < target) begin
            run_list();
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("posting_list_delta_decoder_core regression: pass");
      end else begin
         $display("posting_list_delta_decoder_core regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/pldd_pkg.sv
src/pldd_front.sv
src/pldd_fifo.sv
src/pldd_back.sv
src/posting_list_delta_decoder_core.sv
dv/tb_posting_list_delta_decoder_core.sv
